// File: hw/rtl/oaht_pkg.sv
// Shared types and constants for the open-addressing hash table.
// Used by oaht_ctrl, oaht_dp, open_address_hash_table and the testbench.
package oaht_pkg;

  // Fixed field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned TBITS_W    = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  // Hashing constants
  localparam int unsigned HASH_MUL   = 37;
  localparam int unsigned PROBE_STEP = 3733;

  // Register reset values
  localparam logic [TBITS_W-1:0] TBITS_RESET = 4'd4;
  localparam logic [CNT_W-1:0]   MAX_RESET   = 9'd12;

  // Request function codes; the unused code acts as a lookup
  localparam logic [FUNC_W-1:0] FUNC_INSERT     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP_ALT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BITS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

  // Sequencer to datapath commands
  typedef struct packed {
    logic load;      // capture request, compute home slot
    logic clr_step;  // clear one slot of the key memory
    logic rd;        // read key and value memories at probe slot
    logic chk;       // evaluate read data, advance probe
    logic emit;      // commit writes, load output register
  } cmd_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic clr_last;   // clearing pass on its final slot
    logic zero_key;   // incoming key is zero
    logic probe_end;  // current probe decides the outcome
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

// File: hw/rtl/oaht_ctrl.sv
// Sequencer for the hash table: clearing pass, probe loop and result hand-off.
// Depends on oaht_pkg for the command and status structs.
module oaht_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  oaht_pkg::sts_t  sts_i,
  output oaht_pkg::cmd_t  cmd_o
);
  import oaht_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.zero_key ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.probe_end ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/oaht_dp.sv
// Datapath for the hash table: config registers, key/value memories, probe
// registers, outcome logic and output register. Depends on oaht_pkg.
module oaht_dp #(
  parameter int unsigned TABLE_BITS = 8,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [oaht_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [oaht_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [oaht_pkg::FUNC_W-1:0]       in_func_i,
  input  logic [KEY_BITS-1:0]               in_key_i,
  input  logic [VALUE_BITS-1:0]             in_value_i,
  input  oaht_pkg::cmd_t                    cmd_i,
  output oaht_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [oaht_pkg::STATUS_W-1:0]     out_status_o,
  output logic [VALUE_BITS-1:0]             out_found_o,
  output logic [oaht_pkg::CNT_W-1:0]        out_total_o
);
  import oaht_pkg::*;

  localparam int unsigned SLOTS = 1 << TABLE_BITS;
  localparam int unsigned KW    = KEY_BITS + 1;  // tombstone mark above key
  localparam logic [TABLE_BITS-1:0] STEP = TABLE_BITS'(PROBE_STEP);
  localparam logic [TABLE_BITS-1:0] MUL  = TABLE_BITS'(HASH_MUL);

  // Slot mask for a table_bits value, clamped to 1..TABLE_BITS
  function automatic logic [TABLE_BITS-1:0] mask_of(input logic [TBITS_W-1:0] bits);
    logic [TABLE_BITS-1:0] m;
    for (int i = 0; i < int'(TABLE_BITS); i++) begin
      m[i] = (i == 0) || (i < int'(bits));
    end
    return m;
  endfunction

  // Memories
  logic [KW-1:0]         kmem [SLOTS];
  logic [VALUE_BITS-1:0] vmem [SLOTS];
  logic [KW-1:0]         rdk_q;
  logic [VALUE_BITS-1:0] rdv_q;

  // Control registers
  logic [TABLE_BITS-1:0] mask_q;
  logic [CNT_W-1:0]      max_q;
  logic [CNT_W-1:0]      count_q;
  logic [TABLE_BITS-1:0] clr_q;
  logic                  free_vld_q;
  logic                  wk_en_q, wv_en_q, inc_q, dec_q;
  logic                  out_valid_q;

  // Payload registers
  logic [FUNC_W-1:0]     func_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [TABLE_BITS-1:0] pos_q, idx_q, free_q, waddr_q;
  logic                  wtomb_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic [VALUE_BITS-1:0] res_found_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [VALUE_BITS-1:0] out_found_q;
  logic [CNT_W-1:0]      out_total_q;

  // Probe evaluation
  logic                  hit, empty, tomb, probe_end, free_any, full;
  logic [TABLE_BITS-1:0] free_addr, home, key_lo;
  logic [CNT_W-1:0]      cnt_next;

  // Outcome plan
  logic [STATUS_W-1:0]   pl_status;
  logic [VALUE_BITS-1:0] pl_found;
  logic                  pl_wk, pl_wv, pl_tomb, pl_inc, pl_dec;
  logic [TABLE_BITS-1:0] pl_addr;

  // Memory write port
  logic                  kmem_we;
  logic [TABLE_BITS-1:0] kmem_waddr;
  logic [KW-1:0]         kmem_wdata;
  logic                  vmem_we;

  // Home slot: only the low key bits reach the masked product
  assign key_lo = TABLE_BITS'(in_key_i);
  assign home   = TABLE_BITS'(key_lo * MUL) & mask_q;

  assign tomb      = rdk_q[KEY_BITS];
  assign hit       = (rdk_q[KEY_BITS-1:0] == key_q);
  assign empty     = (rdk_q[KEY_BITS-1:0] == '0);
  assign probe_end = hit || (empty && !tomb) || (idx_q == mask_q);
  assign free_any  = free_vld_q || empty;
  assign free_addr = free_vld_q ? free_q : pos_q;
  assign full      = (count_q >= max_q) || !free_any;

  always_comb begin
    pl_status = ST_NOT_FOUND;
    pl_found  = '0;
    pl_wk     = 1'b0;
    pl_wv     = 1'b0;
    pl_tomb   = 1'b0;
    pl_inc    = 1'b0;
    pl_dec    = 1'b0;
    pl_addr   = pos_q;
    case (func_q)
      FUNC_INSERT: begin
        if (hit) begin
          pl_status = ST_UPDATED;
          pl_wv     = 1'b1;
        end else if (full) begin
          pl_status = ST_FULL;
        end else begin
          pl_status = ST_INSERTED;
          pl_wk     = 1'b1;
          pl_wv     = 1'b1;
          pl_inc    = 1'b1;
          pl_addr   = free_addr;
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          pl_status = ST_REMOVED;
          pl_wk     = 1'b1;
          pl_tomb   = 1'b1;
          pl_dec    = (count_q != '0);
        end
      end
      default: begin
        // lookup; the unused code also lands here
        if (hit) begin
          pl_status = ST_FOUND;
          pl_found  = rdv_q;
        end
      end
    endcase
  end

  always_comb begin
    if (inc_q) begin
      cnt_next = count_q + 1'b1;
    end else if (dec_q) begin
      cnt_next = count_q - 1'b1;
    end else begin
      cnt_next = count_q;
    end
  end

  // Status to sequencer
  assign sts_o.clr_last  = (clr_q == '1);
  assign sts_o.zero_key  = (in_key_i == '0);
  assign sts_o.probe_end = probe_end;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Key memory write: clearing pass or committed write
  assign kmem_we    = cmd_i.clr_step || (cmd_i.emit && wk_en_q);
  assign kmem_waddr = cmd_i.clr_step ? clr_q : waddr_q;
  assign kmem_wdata = (cmd_i.clr_step || wtomb_q) ? {cmd_i.clr_step ? 1'b0 : 1'b1,
                                                     {KEY_BITS{1'b0}}}
                                                  : {1'b0, key_q};
  assign vmem_we    = cmd_i.emit && wv_en_q;

  always_ff @(posedge clk_i) begin
    if (kmem_we) begin
      kmem[kmem_waddr] <= kmem_wdata;
    end
    if (cmd_i.rd) begin
      rdk_q <= kmem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      vmem[waddr_q] <= val_q;
    end
    if (cmd_i.rd) begin
      rdv_q <= vmem[pos_q];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= mask_of(TBITS_RESET);
      max_q       <= MAX_RESET;
      count_q     <= '0;
      clr_q       <= '0;
      free_vld_q  <= 1'b0;
      wk_en_q     <= 1'b0;
      wv_en_q     <= 1'b0;
      inc_q       <= 1'b0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TABLE_BITS:  mask_q <= mask_of(cfg_data_i[TBITS_W-1:0]);
          CFG_MAX_ENTRIES: max_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load) begin
        free_vld_q <= 1'b0;
        wk_en_q    <= 1'b0;
        wv_en_q    <= 1'b0;
        inc_q      <= 1'b0;
        dec_q      <= 1'b0;
      end
      if (cmd_i.chk) begin
        if (probe_end) begin
          wk_en_q <= pl_wk;
          wv_en_q <= pl_wv;
          inc_q   <= pl_inc;
          dec_q   <= pl_dec;
        end else if (empty) begin
          free_vld_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        count_q     <= cnt_next;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q       <= in_func_i;
      key_q        <= in_key_i;
      val_q        <= in_value_i;
      pos_q        <= home;
      idx_q        <= '0;
      res_status_q <= ST_ZERO_KEY;
      res_found_q  <= '0;
    end
    if (cmd_i.chk) begin
      if (probe_end) begin
        res_status_q <= pl_status;
        res_found_q  <= pl_found;
        waddr_q      <= pl_addr;
        wtomb_q      <= pl_tomb;
      end else begin
        pos_q <= (pos_q + STEP) & mask_q;
        idx_q <= idx_q + 1'b1;
        if (empty && !free_vld_q) begin
          free_q <= pos_q;
        end
      end
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_total_q  <= cnt_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_found_o  = out_found_q;
  assign out_total_o  = out_total_q;

endmodule

// File: hw/rtl/open_address_hash_table.sv
// Open-addressing key/value table, fixed-stride probing, tombstone removal.
// Each request is loaded, then each probe is a registered read followed by a check;
// a zero key skips probing. The result waits for a free output register.
// A new request is taken in the cycle after the result is registered, not before.
// Reset starts a clearing pass over all 2^TABLE_BITS slots (256 by default) that
// empties the key memory; no request is accepted until it ends.
module open_address_hash_table #(
  parameter int unsigned TABLE_BITS = 8,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [oaht_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [oaht_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low bit up: func, key, value, zero pad
  input  logic [((oaht_pkg::FUNC_W + KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0]
                                          s_axis_tdata,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low bit up: status, found_value, entry_total, zero pad
  output logic [((oaht_pkg::STATUS_W + VALUE_BITS + oaht_pkg::CNT_W + 7) / 8) * 8 - 1:0]
                                          m_axis_tdata
);
  import oaht_pkg::*;

  localparam int unsigned OUT_TW = ((STATUS_W + VALUE_BITS + CNT_W + 7) / 8) * 8;

  cmd_t                  cmd;
  sts_t                  sts;
  logic [FUNC_W-1:0]     in_func;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;
  logic [STATUS_W-1:0]   out_status;
  logic [VALUE_BITS-1:0] out_found;
  logic [CNT_W-1:0]      out_total;

  // Beat unpack and pack
  assign in_func      = s_axis_tdata[FUNC_W-1:0];
  assign in_key       = s_axis_tdata[FUNC_W +: KEY_BITS];
  assign in_value     = s_axis_tdata[FUNC_W + KEY_BITS +: VALUE_BITS];
  assign m_axis_tdata = OUT_TW'({out_total, out_found, out_status});

  // Registers accept writes in any cycle
  assign cfg_ready_o = 1'b1;

  oaht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  oaht_dp #(
    .TABLE_BITS (TABLE_BITS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_func_i    (in_func),
    .in_key_i     (in_key),
    .in_value_i   (in_value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_found_o  (out_found),
    .out_total_o  (out_total)
  );

  // Sequencer issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.clr_step, cmd.rd, cmd.chk, cmd.emit}))
    else $error("more than one datapath command in a cycle");

  // Every memory read is evaluated in the next cycle
  a_rd_then_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd |=> cmd.chk)
    else $error("probe read not followed by a check");

  // A committed result shows up on the output
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> m_axis_tvalid)
    else $error("result not presented after commit");

  // A successful insert leaves at least one live entry
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_status == ST_INSERTED)) |-> (out_total != '0))
    else $error("insert reported with zero entry count");

endmodule
